/* hw/rtl/dhpg_pkg.sv */
// ----------------------------------------------------------------------------
// dhpg_pkg
// Shared types, constants and hash step functions for the double-hash probe
// generator.
// ----------------------------------------------------------------------------
package dhpg_pkg;

  // Table size; must be a power of two so the probe step stays odd.
  localparam int unsigned SLOT_COUNT = 512;
  localparam int unsigned SLOT_W     = 9;
  localparam logic [31:0] SLOT_MASK  = 32'(SLOT_COUNT - 1);

  localparam logic [31:0] ROT_TOP_MASK  = 32'hf8000000;
  localparam logic [31:0] ROT_LOW_MASK  = 32'h07ffffff;
  localparam logic [31:0] FOLD_LOW_MASK = 32'h0fffffff;
  localparam logic [31:0] FOLD_TOP_MASK = 32'hf0000000;
  localparam int unsigned ROT_TOP_SHIFT  = 27;
  localparam int unsigned FOLD_TOP_SHIFT = 24;

  typedef struct packed {
    logic [31:0] rot_acc;
    logic [31:0] fold_acc;
    logic        expect_first;
  } hash_state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] home_slot;
    logic [SLOT_W-1:0] probe_step;
    logic [31:0]       primary_hash;
    logic [31:0]       secondary_hash;
  } hash_result_t;

  function automatic logic [31:0] rot_advance(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] top;
    logic [31:0] r;
    top = h & ROT_TOP_MASK;
    r   = (h & ROT_LOW_MASK) << 5;
    r   = r ^ (top >> ROT_TOP_SHIFT);
    r   = r ^ {24'd0, c};
    return r;
  endfunction

  function automatic logic [31:0] fold_advance(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] r;
    logic [31:0] top;
    r   = (h & FOLD_LOW_MASK) << 4;
    r   = r + {24'd0, c};
    top = r & FOLD_TOP_MASK;
    if (top != 32'd0) begin
      r = r ^ (top >> FOLD_TOP_SHIFT);
      r = r ^ top;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/dhpg_hash_step.sv */
// ----------------------------------------------------------------------------
// dhpg_hash_step
// Combinational update of both running hashes for one byte, plus the
// terminator step and slot/probe derivation for a final byte.
// ----------------------------------------------------------------------------
module dhpg_hash_step (
  input  dhpg_pkg::hash_state_t  state,
  input  logic [7:0]             name_byte,
  input  logic                   last_byte,
  output dhpg_pkg::hash_state_t  state_next,
  output dhpg_pkg::hash_result_t result
);
  import dhpg_pkg::*;

  logic [31:0] rot_h;
  logic [31:0] fold_h;
  logic [31:0] p;
  logic [31:0] s;

  always_comb begin
    // first byte of a name seeds both hashes directly
    if (state.expect_first) begin
      rot_h  = {24'd0, name_byte};
      fold_h = {24'd0, name_byte};
    end else begin
      rot_h  = rot_advance(state.rot_acc, name_byte);
      fold_h = fold_advance(state.fold_acc, name_byte);
    end

    // implicit zero terminator
    p = rot_advance(rot_h, 8'd0);
    s = fold_advance(fold_h, 8'd0) | 32'd1;

    result.home_slot      = SLOT_W'(p & SLOT_MASK);
    result.probe_step     = SLOT_W'(s & SLOT_MASK);
    result.primary_hash   = p;
    result.secondary_hash = s;

    if (last_byte) begin
      state_next.rot_acc      = 32'd0;
      state_next.fold_acc     = 32'd0;
      state_next.expect_first = 1'b1;
    end else begin
      state_next.rot_acc      = rot_h;
      state_next.fold_acc     = fold_h;
      state_next.expect_first = 1'b0;
    end
  end

endmodule

/* hw/rtl/double_hash_probe_generator_unit.sv */
// ----------------------------------------------------------------------------
// double_hash_probe_generator_unit
// Streams name bytes through two 32-bit string hashes and emits the home
// slot and odd probe step for double hashing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one name byte per item, last_byte
//   set on the final character. An empty name is one zero byte with
//   last_byte set.
//   Output channel (out_valid/out_stall): one item per name, carrying the
//   home slot, probe step and both full hashes.
// Timing:
//   One byte per cycle while no final byte is held by out_stall. A byte
//   is first registered in the input register and then hashed into the
//   accumulators; for a final byte the result enters the output register
//   at that same edge and out_valid rises with it.
// Reset:
//   rst clears both accumulators and the valid flags; the next byte starts
//   a new name.
// Stall:
//   While a result waits under out_stall, non-final bytes still flow into
//   the accumulators; a final byte holds in the input register, and
//   in_stall rises only when that register cannot drain.
// ----------------------------------------------------------------------------
module double_hash_probe_generator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 name_byte,
  input  logic                       last_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dhpg_pkg::SLOT_W-1:0] home_slot,
  output logic [dhpg_pkg::SLOT_W-1:0] probe_step,
  output logic [31:0]                primary_hash,
  output logic [31:0]                secondary_hash
);
  import dhpg_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  hash_state_t  state;
  hash_state_t  state_next;
  hash_result_t result;

  logic out_free;
  logic s1_fire;
  logic in_fire;
  logic out_load;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_fire;
  assign in_fire  = in_valid && !in_stall;
  assign out_load = s1_fire && s1_last;

  dhpg_hash_step u_step (
    .state      (state),
    .name_byte  (s1_byte),
    .last_byte  (s1_last),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= name_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.rot_acc      <= 32'd0;
      state.fold_acc     <= 32'd0;
      state.expect_first <= 1'b1;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      home_slot      <= result.home_slot;
      probe_step     <= result.probe_step;
      primary_hash   <= result.primary_hash;
      secondary_hash <= result.secondary_hash;
    end
  end

`ifndef SYNTH
  a_out_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (secondary_hash[0] && probe_step[0]))
    else $error("result hash or probe step is even");

  a_restart_after_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state.expect_first && state.rot_acc == 32'd0 && state.fold_acc == 32'd0))
    else $error("accumulators not cleared after a result");

  a_stall_only_final: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid && out_stall))
    else $error("input stalled without a blocked final byte");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(primary_hash)))
    else $error("stalled result lost or changed");
`endif

endmodule
